>>> design/cds_pkg.sv
// Shared types and constants for the 4:2:0 chroma downsampler.
// Used by cds_burst and chroma_downsample_420_pad8; depends on nothing else.
package cds_pkg;

	// Default sizing of the line store and the plane padding.
	localparam int MAX_WIDTH_DEF    = 4096;
	localparam int PAD_MULTIPLE_DEF = 8;

	// Fixed field widths.
	localparam int PIX_W     = 8;             // one chroma sample
	localparam int PAIR_W    = PIX_W + 1;     // sum of two samples
	localparam int SUM_W     = PIX_W + 2;     // sum of four samples
	localparam int DIM_W     = 13;            // image size registers
	localparam int CNT_W     = 12;            // pixel column and row counters
	localparam int HALF_W    = CNT_W - 1;     // plane coordinate of a pixel pair
	localparam int COORD_W   = DIM_W - 1;     // plane coordinate including padding
	localparam int PLANE_W   = 11;            // plane coordinate on the result port
	localparam int LINE_W    = 2 * PAIR_W;    // one line store entry, Cr above Cb
	localparam int CFG_IDX_W = 2;

	localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
	localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1
	} cfg_reg_t;

	// One finished plane sample together with the run of padded copies it spans.
	typedef struct packed {
		logic [SUM_W-1:0]   cb_sum;
		logic [SUM_W-1:0]   cr_sum;
		logic [HALF_W-1:0]  row_start;
		logic [HALF_W-1:0]  col_start;
		logic [COORD_W-1:0] row_end;
		logic [COORD_W-1:0] col_end;
	} burst_cmd_t;

endpackage

>>> design/cds_burst.sv
// Result stage of the chroma downsampler: holds one plane sample and walks its padded copies.
// Depends on cds_pkg for the command struct and field widths.
module cds_burst import cds_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_valid,
	input  burst_cmd_t         load_cmd,
	output logic               load_ready,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [SUM_W-1:0]   cb_avg_x4,
	output logic [SUM_W-1:0]   cr_avg_x4,
	output logic [PLANE_W-1:0] plane_row,
	output logic [PLANE_W-1:0] plane_col,
	output logic               run_last
);

	logic               busy_q;
	logic [SUM_W-1:0]   cb_q;
	logic [SUM_W-1:0]   cr_q;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] col_start_q;
	logic [COORD_W-1:0] row_end_q;
	logic [COORD_W-1:0] col_end_q;
	logic               row_done;
	logic               last;
	logic               load_go;
	logic               res_go;

	assign row_done   = (col_q == col_end_q);
	assign last       = row_done && (row_q == row_end_q);
	assign load_ready = !busy_q || (res_ready && last);
	assign load_go    = load_valid && load_ready;
	assign res_go     = busy_q && res_ready;

	assign res_valid = busy_q;
	assign cb_avg_x4 = cb_q;
	assign cr_avg_x4 = cr_q;
	assign plane_row = row_q[PLANE_W-1:0];
	assign plane_col = col_q[PLANE_W-1:0];
	assign run_last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load_go) begin
			busy_q <= 1'b1;
		end else if (res_go && last) begin
			busy_q <= 1'b0;
		end
	end

	// Copies go out row by row, each row from the sample's own column rightward.
	always_ff @(posedge clk) begin
		if (load_go) begin
			cb_q        <= load_cmd.cb_sum;
			cr_q        <= load_cmd.cr_sum;
			row_q       <= {1'b0, load_cmd.row_start};
			col_q       <= {1'b0, load_cmd.col_start};
			col_start_q <= {1'b0, load_cmd.col_start};
			row_end_q   <= load_cmd.row_end;
			col_end_q   <= load_cmd.col_end;
		end else if (res_go) begin
			if (row_done) begin
				row_q <= row_q + COORD_W'(1);
				col_q <= col_start_q;
			end else begin
				col_q <= col_q + COORD_W'(1);
			end
		end
	end

endmodule

>>> design/chroma_downsample_420_pad8.sv
// Top level of the 4:2:0 chroma downsampler with padding of the chroma plane.
// Depends on cds_pkg and on cds_burst, which drives the result port.

// The block takes one full-resolution (Cb, Cr) pixel per beat in raster order and, for every
// 2x2 group, returns the sums of its four Cb and four Cr samples (the average in unsigned 8.2
// fixed point) with the group's row and column in the chroma plane. A result is started by the
// bottom-right pixel of its group. The plane is padded up to a multiple of
// PAD_MULTIPLE samples in each direction: the last real column is copied rightward and the last
// real row downward, and the copies follow their source sample at once, row by row. run_last
// marks the final result caused by one pixel. Throughput is one pixel per clock while the input
// is not stalled; the result register sends one result per clock while res_ready is high, so a
// pixel that closes a group in the last real column or row of the plane keeps the result port
// busy until all of its copies have left, at most PAD_MULTIPLE squared. Pixels keep flowing
// during such a run until the next closing group reaches stage 1; from then on the input stalls
// until the last copy has left. A closing pixel enters stage 1 with its line store read, and
// the result register loads from both. The horizontal pair sums of every even pixel row
// live in a single-port-style line store of MAX_WIDTH/2 entries, written on even rows and read
// on odd rows; the store needs no clearing because each odd row is always preceded by its even
// row. Sizes above MAX_WIDTH are treated as MAX_WIDTH, sizes below two give an empty plane, and
// a trailing odd column or row is consumed without results. Writing either size register
// returns the block to the start of a frame; write only while no results are pending.
module chroma_downsample_420_pad8 import cds_pkg::*; #(
	parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
	parameter int PAD_MULTIPLE = PAD_MULTIPLE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 pix_valid,
	output logic                 pix_ready,
	input  logic [PIX_W-1:0]     cb_sample,
	input  logic [PIX_W-1:0]     cr_sample,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [SUM_W-1:0]     cb_avg_x4,
	output logic [SUM_W-1:0]     cr_avg_x4,
	output logic [PLANE_W-1:0]   plane_row,
	output logic [PLANE_W-1:0]   plane_col,
	output logic                 run_last
);

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int LA_W       = $clog2(LINE_DEPTH);
	localparam int PM_W       = (PAD_MULTIPLE > 1) ? $clog2(PAD_MULTIPLE) : 1;
	localparam int DIM_MAX    = (1 << DIM_W) - 1;
	localparam int CLAMP      = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;

	localparam logic [DIM_W-1:0]   DIM_CLAMP = DIM_W'(CLAMP);
	localparam logic [PM_W-1:0]    PM_TOP    = PM_W'(PAD_MULTIPLE - 1);
	localparam logic [COORD_W-1:0] PAD_TOP   = COORD_W'(PAD_MULTIPLE - 1);

	// Configuration registers.
	logic [DIM_W-1:0] img_w_q;
	logic [DIM_W-1:0] img_h_q;

	// Position of the next pixel, and the plane coordinates modulo the pad multiple.
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [PM_W-1:0]  cmod_q;
	logic [PM_W-1:0]  rmod_q;

	// Even-column pixel waiting for its right neighbor.
	logic [PIX_W-1:0] held_cb_q;
	logic [PIX_W-1:0] held_cr_q;

	// Line store of even-row pair sums and its registered read port.
	logic [LINE_W-1:0] line_mem [LINE_DEPTH];
	logic [LINE_W-1:0] rd_q;

	// Stage 1: a pixel that closes a 2x2 group, held beside the line store read data.
	logic               valid_s1;
	logic [PAIR_W-1:0]  sb_s1;
	logic [PAIR_W-1:0]  sr_s1;
	logic [HALF_W-1:0]  r2_s1;
	logic [HALF_W-1:0]  c2_s1;
	logic [COORD_W-1:0] rend_s1;
	logic [COORD_W-1:0] cend_s1;

	logic [DIM_W-1:0]   we_eff;
	logic [DIM_W-1:0]   he_eff;
	logic [DIM_W-1:0]   w_line;
	logic [DIM_W-1:0]   h_frame;
	logic [COORD_W-1:0] cw;
	logic [COORD_W-1:0] ch;
	logic [HALF_W-1:0]  c2;
	logic [HALF_W-1:0]  r2;
	logic               in_plane;
	logic [PAIR_W-1:0]  sb;
	logic [PAIR_W-1:0]  sr;
	logic [LA_W-1:0]    line_addr;
	logic               pix_go;
	logic               line_wr;
	logic               line_rd;
	logic [DIM_W-1:0]   col_inc;
	logic [DIM_W-1:0]   row_inc;
	logic               line_end;
	logic               frame_end;
	logic [CNT_W-1:0]   col_nxt;
	logic [CNT_W-1:0]   row_nxt;
	logic [PM_W-1:0]    cmod_nxt;
	logic [PM_W-1:0]    rmod_nxt;
	logic [COORD_W-1:0] cend;
	logic [COORD_W-1:0] rend;
	logic               cfg_hit;
	logic               burst_ready;
	burst_cmd_t         burst_cmd;

	// The block takes a register write on any cycle.
	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT);

	// Effective frame geometry.
	assign we_eff  = (img_w_q > DIM_CLAMP) ? DIM_CLAMP : img_w_q;
	assign he_eff  = (img_h_q > DIM_CLAMP) ? DIM_CLAMP : img_h_q;
	assign w_line  = (we_eff == '0) ? DIM_W'(1) : we_eff;
	assign h_frame = (he_eff == '0) ? DIM_W'(1) : he_eff;
	assign cw      = we_eff[DIM_W-1:1];
	assign ch      = he_eff[DIM_W-1:1];

	assign c2       = col_q[CNT_W-1:1];
	assign r2       = row_q[CNT_W-1:1];
	assign in_plane = ({1'b0, c2} < cw) && ({1'b0, r2} < ch);

	assign sb = {1'b0, held_cb_q} + {1'b0, cb_sample};
	assign sr = {1'b0, held_cr_q} + {1'b0, cr_sample};

	assign pix_ready = !valid_s1 || burst_ready;
	assign pix_go    = pix_valid && pix_ready;
	assign line_wr   = pix_go && col_q[0] && !row_q[0] && in_plane;
	assign line_rd   = pix_go && col_q[0] && row_q[0] && in_plane;
	assign line_addr = LA_W'(c2);

	// Pixel position advance, with the line and frame wrap.
	assign col_inc   = {1'b0, col_q} + DIM_W'(1);
	assign row_inc   = {1'b0, row_q} + DIM_W'(1);
	assign line_end  = (col_inc >= w_line);
	assign frame_end = (row_inc >= h_frame);
	assign col_nxt   = line_end ? '0 : col_inc[CNT_W-1:0];
	assign row_nxt   = !line_end ? row_q : (frame_end ? '0 : row_inc[CNT_W-1:0]);

	// The modulo counters follow the plane coordinate, so the padding end needs no divider.
	always_comb begin
		if (col_nxt == '0) begin
			cmod_nxt = '0;
		end else if (col_q[0]) begin
			cmod_nxt = (cmod_q == PM_TOP) ? '0 : cmod_q + PM_W'(1);
		end else begin
			cmod_nxt = cmod_q;
		end
		if (!line_end) begin
			rmod_nxt = rmod_q;
		end else if (row_nxt == '0) begin
			rmod_nxt = '0;
		end else if (row_q[0]) begin
			rmod_nxt = (rmod_q == PM_TOP) ? '0 : rmod_q + PM_W'(1);
		end else begin
			rmod_nxt = rmod_q;
		end
	end

	// The last real column or row extends to the next pad boundary; others emit only themselves.
	assign cend = (({1'b0, c2} + COORD_W'(1)) == cw)
		? {1'b0, c2} + (PAD_TOP - COORD_W'(cmod_q)) : {1'b0, c2};
	assign rend = (({1'b0, r2} + COORD_W'(1)) == ch)
		? {1'b0, r2} + (PAD_TOP - COORD_W'(rmod_q)) : {1'b0, r2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= WIDTH_RST;
			img_h_q <= HEIGHT_RST;
			col_q   <= '0;
			row_q   <= '0;
			cmod_q  <= '0;
			rmod_q  <= '0;
		end else if (cfg_hit) begin
			case (cfg_index)
				CFG_WIDTH:  img_w_q <= cfg_data;
				CFG_HEIGHT: img_h_q <= cfg_data;
				default:    ;
			endcase
			col_q  <= '0;
			row_q  <= '0;
			cmod_q <= '0;
			rmod_q <= '0;
		end else if (pix_go) begin
			col_q  <= col_nxt;
			row_q  <= row_nxt;
			cmod_q <= cmod_nxt;
			rmod_q <= rmod_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cb_q <= '0;
			held_cr_q <= '0;
		end else if (pix_go && !col_q[0]) begin
			held_cb_q <= cb_sample;
			held_cr_q <= cr_sample;
		end
	end

	// An even row writes its pair sums; the odd row below reads them back at least one beat
	// later, so the read always sees the completed write.
	always_ff @(posedge clk) begin
		if (line_wr) begin
			line_mem[line_addr] <= {sr, sb};
		end
		if (line_rd) begin
			rd_q <= line_mem[line_addr];
		end
	end

	// Stage 1 takes a new group only when it is empty or hands its group on in the same cycle,
	// so the read data register stays matched to the group it holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_go) begin
			valid_s1 <= line_rd;
		end else if (burst_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (line_rd) begin
			sb_s1   <= sb;
			sr_s1   <= sr;
			r2_s1   <= r2;
			c2_s1   <= c2;
			rend_s1 <= rend;
			cend_s1 <= cend;
		end
	end

	// Vertical sum of the current pair with the stored pair above it.
	assign burst_cmd.cb_sum    = {1'b0, sb_s1} + {1'b0, rd_q[PAIR_W-1:0]};
	assign burst_cmd.cr_sum    = {1'b0, sr_s1} + {1'b0, rd_q[LINE_W-1:PAIR_W]};
	assign burst_cmd.row_start = r2_s1;
	assign burst_cmd.col_start = c2_s1;
	assign burst_cmd.row_end   = rend_s1;
	assign burst_cmd.col_end   = cend_s1;

	cds_burst u_burst (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_cmd   (burst_cmd),
		.load_ready (burst_ready),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.cb_avg_x4  (cb_avg_x4),
		.cr_avg_x4  (cr_avg_x4),
		.plane_row  (plane_row),
		.plane_col  (plane_col),
		.run_last   (run_last)
	);

endmodule
